[rtl/owo_pkg.sv]
// Package: payload word types, state encoding and CORDIC constants for omni wheel odometry.
package owo_pkg;

  typedef struct packed {
    logic signed [15:0] wheel_a_count;
    logic signed [15:0] wheel_b_count;
    logic signed [15:0] wheel_c_count;
  } owo_in_t;

  typedef struct packed {
    logic signed [47:0] pose_x;
    logic signed [47:0] pose_y;
    logic        [31:0] heading;
    logic signed [39:0] speed_x;
    logic signed [39:0] speed_y;
    logic signed [47:0] turn_rate;
  } owo_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_SUM,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } owo_state_t;

  localparam logic signed [33:0] CordicX0 = 34'sd652032874;
  localparam logic [29:0] AnglePerRad = 30'd683565276;
  localparam logic [34:0] TwoPiQ32 = 35'd26986075409;
  localparam int CordicSteps = 30;

  function automatic logic signed [33:0] atan_ba(input logic [4:0] i);
    logic signed [33:0] r;
    begin
      case (i)
        5'd0: r = 34'sd536870912;
        5'd1: r = 34'sd316933406;
        5'd2: r = 34'sd167458907;
        5'd3: r = 34'sd85004756;
        5'd4: r = 34'sd42667331;
        5'd5: r = 34'sd21354465;
        5'd6: r = 34'sd10679838;
        5'd7: r = 34'sd5340245;
        5'd8: r = 34'sd2670163;
        5'd9: r = 34'sd1335087;
        5'd10: r = 34'sd667544;
        5'd11: r = 34'sd333772;
        5'd12: r = 34'sd166886;
        5'd13: r = 34'sd83443;
        5'd14: r = 34'sd41722;
        5'd15: r = 34'sd20861;
        5'd16: r = 34'sd10430;
        5'd17: r = 34'sd5215;
        5'd18: r = 34'sd2608;
        5'd19: r = 34'sd1304;
        5'd20: r = 34'sd652;
        5'd21: r = 34'sd326;
        5'd22: r = 34'sd163;
        5'd23: r = 34'sd81;
        5'd24: r = 34'sd41;
        5'd25: r = 34'sd20;
        5'd26: r = 34'sd10;
        5'd27: r = 34'sd5;
        5'd28: r = 34'sd3;
        5'd29: r = 34'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

[rtl/owo_serial_mul.sv]
// Shift-and-add multiplier: signed multiplicand, unsigned multiplier, two bits per cycle.
module owo_serial_mul #(
  parameter int AW = 64,
  parameter int BW = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic        [BW-1:0]    b,
  output logic                    busy,
  output logic signed [AW+BW-1:0] prod
);
  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 2);

  logic signed [PW-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0] mcand_r, mcand_nxt;
  logic [BW-1:0] mplier_r, mplier_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt = '0;
      mcand_nxt = PW'(a);
      mplier_nxt = b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + (mplier_r[0] ? mcand_r : '0) +
                (mplier_r[1] ? (mcand_r <<< 1) : '0);
      mcand_nxt = mcand_r <<< 2;
      mplier_nxt = mplier_r >> 2;
      cnt_nxt = cnt_r + CW'(2);
      if (cnt_r + CW'(2) >= CW'(BW)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign busy = busy_r;
  assign prod = acc_r;
endmodule

[rtl/owo_serial_div.sv]
// Restoring divider giving the floor of a signed dividend over a positive divisor, one bit per cycle.
module owo_serial_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic        [DW-1:0] den,
  output logic                 busy,
  output logic signed [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [DW:0] trial;
  logic [NW-1:0] mag;

  // floor(-m/d) = -(floor((m-1)/d)) - 1 for m > 0
  assign mag = num[NW-1] ? (~num) : num;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = mag;
      rem_nxt = '0;
      den_nxt = den;
      neg_nxt = num[NW-1];
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NW - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = busy_r;
  assign quo = neg_r ? ~q_r : q_r;
endmodule

[rtl/omni_wheel_odometry_core.sv]
// Top level: three-wheel omni odometry with serial CORDIC, multiply and divide units.
// Usage notes
// The input channel (in_valid, in_stall, in_word) carries three signed encoder
// deltas per word. The result channel (out_valid, out_stall, out_word) carries
// pose, heading and body velocities. The core takes one word when idle.
// Sequence from the accepting edge to out_valid: 30 CORDIC steps, bit-serial
// coefficient sums over the 16 count bits, ten multiplies (two bits a cycle)
// and four floor divides (one bit a cycle), then the result register loads.
// The pace is set by the shared serial multiplier and divider: no new word is
// taken while one is in flight, and the next word is taken in the idle cycle
// after the result loads.
// cfg_we/cfg_wdata write integration_mode (bit 0): 0 rectangular, 1 trapezoid.
// Reset (rst_n low, synchronous) clears pose, heading, previous speeds and
// sets trapezoid mode. While out_stall is high the result word holds; the core
// still takes and finishes one more word, then waits and stalls its input.
module omni_wheel_odometry_core #(
  parameter int COUNTS_PER_REV = 1000,
  parameter int WHEEL_RADIUS_MM = 60,
  parameter int BODY_RADIUS_MM = 144,
  parameter int TICK_US = 1000
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  owo_pkg::owo_in_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output owo_pkg::owo_out_t out_word,
  input  logic             cfg_we,
  input  logic             cfg_wdata
);
  import owo_pkg::*;

  localparam longint CprTick = longint'(COUNTS_PER_REV) * longint'(TICK_US);
  localparam longint Gain = (longint'(TwoPiQ32) * 64'sd1000000 + CprTick / 2) / CprTick;
  localparam longint Lim62 = (64'sd1 <<< 62) - 1;
  localparam longint Lim47 = (64'sd1 <<< 47) - 1;
  localparam longint Lim39 = (64'sd1 <<< 39) - 1;
  localparam int SumSteps = 16;

  // op codes of the step sequencer
  typedef enum logic [3:0] {
    OP_VX1, OP_VX2, OP_VY1, OP_VY2, OP_OM1, OP_OM2, OP_OM3,
    OP_PX1, OP_PX2, OP_PY1, OP_PY2, OP_H1, OP_H2, OP_H3, OP_END
  } op_t;

  owo_state_t st_r, st_nxt;
  op_t op_r, op_nxt;
  logic mode_r;
  logic [4:0] it_r, it_nxt;

  logic signed [47:0] px_r, py_r;
  logic [31:0] hd_r;
  logic signed [39:0] lvx_r, lvy_r;
  logic signed [47:0] lom_r;
  logic signed [39:0] vx_r, vy_r;
  logic signed [47:0] om_r;
  logic signed [15:0] n0_r, n1_r, n2_r;
  logic signed [34:0] cx_r, cy_r, cz_r;
  logic flip_r;
  logic signed [63:0] ax_r, ay_r, t_r;
  logic out_valid_r;
  owo_out_t out_r;

  logic mul_start, div_start, mul_busy, div_busy;
  logic signed [63:0] mul_a, div_num;
  logic [63:0] mul_b;
  logic [31:0] div_den;
  logic signed [127:0] mul_p;
  logic signed [63:0] div_q;
  logic [5:0] mul_sh;
  logic [63:0] mul_lim;

  owo_serial_mul #(.AW(64), .BW(64)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .prod(mul_p)
  );

  owo_serial_div #(.NW(64), .DW(32)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_q)
  );

  logic in_fire, out_fire, done_go;
  assign in_fire = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign in_stall = (st_r != ST_IDLE);
  assign done_go = (st_r == ST_DONE) && (!out_valid_r || !out_stall);

  // saturating floor shift of the product
  logic signed [127:0] shifted;
  logic signed [63:0] sat_res;
  always_comb begin
    shifted = mul_p >>> mul_sh;
    if (shifted > $signed({64'd0, mul_lim})) sat_res = mul_lim;
    else if (shifted < -$signed({64'd0, mul_lim}) - 128'sd1) sat_res = -mul_lim - 64'sd1;
    else sat_res = shifted[63:0];
  end

  // CORDIC step
  logic signed [34:0] dx, dy, sv, cv;
  logic signed [63:0] s64, c64, n0e, n1e;
  assign dx = cy_r >>> it_r;
  assign dy = cx_r >>> it_r;
  assign sv = flip_r ? -cy_r : cy_r;
  assign cv = flip_r ? -cx_r : cx_r;
  assign s64 = 64'(sv);
  assign c64 = 64'(cv);
  assign n0e = 64'(n0_r);
  assign n1e = 64'(n1_r);

  // coefficient sums, count bits MSB first; the sign bit weighs negative
  logic signed [63:0] sum_x, sum_y;
  logic first_bit;
  assign first_bit = (it_r == 5'd0);
  always_comb begin
    sum_x = '0;
    sum_y = '0;
    if (n0_r[15]) begin
      sum_x = sum_x - (c64 + s64);
      sum_y = sum_y + (c64 - s64);
    end
    if (n1_r[15]) begin
      sum_x = sum_x + (s64 - c64);
      sum_y = sum_y - (s64 + c64);
    end
    if (n2_r[15]) begin
      sum_x = sum_x + (c64 <<< 1);
      sum_y = sum_y + (s64 <<< 1);
    end
    if (first_bit) begin
      sum_x = -sum_x;
      sum_y = -sum_y;
    end
  end

  logic signed [63:0] trap_x, trap_y, trap_o;
  assign trap_x = mode_r ? 64'(lvx_r) + 64'(vx_r) : 64'(vx_r);
  assign trap_y = mode_r ? 64'(lvy_r) + 64'(vy_r) : 64'(vy_r);
  assign trap_o = mode_r ? 64'(lom_r) + 64'(om_r) : 64'(om_r);

  always_comb begin
    mul_a = t_r;
    mul_b = 64'(Gain);
    mul_sh = 6'd0;
    mul_lim = 64'(Lim62);
    div_num = t_r;
    div_den = 32'd125000;
    unique case (op_r)
      OP_VX1: begin mul_a = ax_r; mul_sh = 6'd46; end
      OP_VX2: begin mul_b = 64'(WHEEL_RADIUS_MM); mul_sh = 6'd10; mul_lim = 64'(Lim39); end
      OP_VY1: begin mul_a = ay_r; mul_sh = 6'd46; end
      OP_VY2: begin mul_b = 64'(WHEEL_RADIUS_MM); mul_sh = 6'd10; mul_lim = 64'(Lim39); end
      OP_OM1: begin mul_a = n0e + n1e; mul_sh = 6'd16; end
      OP_OM2: mul_b = 64'(WHEEL_RADIUS_MM);
      OP_OM3: div_den = 32'(4 * BODY_RADIUS_MM);
      OP_PX1: begin mul_a = trap_x; mul_b = 64'(TICK_US * 32); end
      OP_PX2: div_den = mode_r ? 32'd250000 : 32'd125000;
      OP_PY1: begin mul_a = trap_y; mul_b = 64'(TICK_US * 32); end
      OP_PY2: div_den = mode_r ? 32'd250000 : 32'd125000;
      OP_H1: begin mul_a = trap_o; mul_b = 64'(TICK_US); end
      OP_H2: begin mul_b = 64'(AnglePerRad); mul_sh = 6'd16; end
      OP_H3: div_den = mode_r ? 32'd2000000 : 32'd1000000;
      default: ;
    endcase
  end

  logic is_div_op;
  assign is_div_op = (op_r == OP_OM3) || (op_r == OP_PX2) || (op_r == OP_PY2) ||
                     (op_r == OP_H3);

  always_comb begin
    st_nxt = st_r;
    op_nxt = op_r;
    it_nxt = it_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (st_r)
      ST_IDLE: if (in_fire) begin st_nxt = ST_CORDIC; it_nxt = '0; end
      ST_CORDIC: begin
        it_nxt = it_r + 5'd1;
        if (it_r == 5'(CordicSteps - 1)) begin
          st_nxt = ST_SUM;
          it_nxt = '0;
        end
      end
      ST_SUM: begin
        it_nxt = it_r + 5'd1;
        if (it_r == 5'(SumSteps - 1)) begin
          st_nxt = ST_MUL;
          op_nxt = OP_VX1;
        end
      end
      ST_MUL: begin
        if (is_div_op) div_start = 1'b1;
        else mul_start = 1'b1;
        st_nxt = ST_DIV;
      end
      ST_DIV: if (!mul_busy && !div_busy) begin
        if (op_r == OP_H3) st_nxt = ST_DONE;
        else begin
          op_nxt = op_t'(op_r + 4'd1);
          st_nxt = ST_MUL;
        end
      end
      ST_DONE: if (!out_valid_r || !out_stall) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic signed [63:0] div_clamped;
  assign div_clamped = (div_q > Lim47) ? Lim47 :
                       (div_q < -Lim47 - 64'sd1) ? -Lim47 - 64'sd1 : div_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      op_r <= OP_VX1;
      it_r <= '0;
      mode_r <= 1'b1;
      px_r <= '0;
      py_r <= '0;
      hd_r <= '0;
      lvx_r <= '0;
      lvy_r <= '0;
      lom_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      op_r <= op_nxt;
      it_r <= it_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
      if (st_r == ST_DIV && !mul_busy && !div_busy) begin
        unique case (op_r)
          OP_PX2: px_r <= px_r + div_q[47:0];
          OP_PY2: py_r <= py_r + div_q[47:0];
          default: ;
        endcase
      end
      if (done_go) begin
        hd_r <= hd_r + t_r[31:0];
        lvx_r <= vx_r;
        lvy_r <= vy_r;
        lom_r <= om_r;
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      n0_r <= in_word.wheel_a_count;
      n1_r <= in_word.wheel_b_count;
      n2_r <= in_word.wheel_c_count;
      flip_r <= hd_r[31] ^ hd_r[30];
      cx_r <= 35'(CordicX0);
      cy_r <= '0;
      cz_r <= 35'($signed(hd_r ^ {hd_r[31] ^ hd_r[30], 31'd0}));
    end
    if (st_r == ST_CORDIC) begin
      if (!cz_r[34]) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - 35'(atan_ba(it_r));
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + 35'(atan_ba(it_r));
      end
    end
    if (st_r == ST_SUM) begin
      ax_r <= (first_bit ? 64'sd0 : (ax_r <<< 1)) + sum_x;
      ay_r <= (first_bit ? 64'sd0 : (ay_r <<< 1)) + sum_y;
      n0_r <= {n0_r[14:0], n0_r[15]};
      n1_r <= {n1_r[14:0], n1_r[15]};
      n2_r <= {n2_r[14:0], n2_r[15]};
    end
    if (st_r == ST_DIV && !mul_busy && !div_busy) begin
      if (is_div_op) begin
        t_r <= div_q;
        if (op_r == OP_OM3) om_r <= div_clamped[47:0];
      end else begin
        t_r <= sat_res;
        if (op_r == OP_VX2) vx_r <= sat_res[39:0];
        if (op_r == OP_VY2) vy_r <= sat_res[39:0];
      end
    end
    if (done_go) begin
      out_r.pose_x <= px_r;
      out_r.pose_y <= py_r;
      out_r.heading <= hd_r + t_r[31:0];
      out_r.speed_x <= vx_r;
      out_r.speed_y <= vy_r;
      out_r.turn_rate <= om_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word = out_r;
endmodule

[rtl/owo_checker.sv]
// Checker: port-level properties of the odometry core, bound to the top level.
module owo_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("accepted twice in a row");
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");
endmodule

bind omni_wheel_odometry_core owo_checker u_owo_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall)
);
